/* rtl/core/differential_drive_odometry_defines.svh */
// Assertion macros shared by the odometry block's checker.
// Depends on nothing; a file that asserts includes it and must have clk_i and rst_ni in scope.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH

// Checked on every clock edge outside reset.
`define DDO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("odometry check failed");

// Checked on every clock edge, reset included.
`define DDO_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("odometry check failed during reset");

`endif

/* rtl/core/ddo_pkg.sv */
// Types, constants and the arctangent table of the odometry block.
// Used by the CORDIC unit, the divider and the top level; depends on nothing.
package ddo_pkg;

  localparam int unsigned PosW      = 32;
  localparam int unsigned AngW      = 16;
  localparam int unsigned TrackW    = 31;
  localparam int unsigned EpsW      = 16;
  localparam int unsigned TrigShift = 30;
  localparam int unsigned MaxSteps  = 24;
  localparam int unsigned DivW      = 64;
  localparam int unsigned DenW      = 34;

  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic [31:0]        TurnPerRad = 32'd683565276;

  typedef enum logic [2:0] {
    REG_TRACK_WIDTH   = 3'd0,
    REG_EPSILON       = 3'd1,
    REG_START_X       = 3'd2,
    REG_START_Y       = 3'd3,
    REG_START_HEADING = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CS1,
    ST_SX,
    ST_SY,
    ST_RMUL,
    ST_RDIV,
    ST_ADIV,
    ST_CS2,
    ST_AX,
    ST_AY,
    ST_POS,
    ST_OUT
  } ddo_state_e;

  typedef struct packed {
    logic               done;
    logic signed [31:0] cos;
    logic signed [31:0] sin;
  } cordic_res_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
  } div_res_t;

  // Arctangent of 2^-i as a fraction of a turn scaled by 2^32.
  function automatic logic [31:0] atan_f(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/ddo_cordic.sv */
// Iterative CORDIC: one rotation per cycle through shared shifters and adders.
// Depends on ddo_pkg for the arctangent table, the gain and the result struct.
module ddo_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [31:0]         angle_i,
  output ddo_pkg::cordic_res_t res_o
);

  localparam int unsigned NSteps = (STEPS < ddo_pkg::MaxSteps) ? STEPS : ddo_pkg::MaxSteps;
  localparam int unsigned CntW   = $clog2(NSteps);
  localparam logic [CntW-1:0] LastIter = CntW'(NSteps - 1);

  logic                   busy_q, done_q, flip_q;
  logic [CntW-1:0]        iter_q;
  logic signed [33:0]     x_q, y_q, z_q;
  logic signed [33:0]     z_in, z_start, xs, ys, at;
  logic                   flip_start;

  // Fold the angle into the right half plane; the result is negated at the end.
  always_comb begin
    z_in       = 34'(signed'(angle_i));
    z_start    = z_in;
    flip_start = 1'b0;
    if (z_in > 34'sh0_4000_0000) begin
      z_start    = z_in - 34'sh0_8000_0000;
      flip_start = 1'b1;
    end else if (z_in < -34'sh0_4000_0000) begin
      z_start    = z_in + 34'sh0_8000_0000;
      flip_start = 1'b1;
    end
    xs = x_q >>> iter_q;
    ys = y_q >>> iter_q;
    at = signed'({2'b00, ddo_pkg::atan_f(5'(iter_q))});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        if (iter_q == LastIter) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          iter_q <= iter_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= ddo_pkg::CordicGain;
      y_q    <= '0;
      z_q    <= z_start;
      flip_q <= flip_start;
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.cos  = 32'(flip_q ? -x_q : x_q);
  assign res_o.sin  = 32'(flip_q ? -y_q : y_q);

endmodule

/* rtl/core/ddo_divider.sv */
// Restoring divider, one quotient bit per cycle, 64 bit dividend.
// Depends on ddo_pkg for widths and the result struct.
module ddo_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ddo_pkg::DivW-1:0]    dividend_i,
  input  logic [ddo_pkg::DenW-1:0]    divisor_i,
  output ddo_pkg::div_res_t           res_o
);

  localparam int unsigned CntW = $clog2(ddo_pkg::DivW);
  localparam logic [CntW-1:0] LastCnt = CntW'(ddo_pkg::DivW - 1);

  logic                          busy_q, done_q;
  logic [CntW-1:0]               cnt_q;
  logic [ddo_pkg::DivW-1:0]      num_q;
  logic [ddo_pkg::DenW-1:0]      rem_q, den_q;
  logic [ddo_pkg::DenW:0]        trial, diff;
  logic                          fits;

  always_comb begin
    trial = {rem_q, num_q[ddo_pkg::DivW-1]};
    diff  = trial - {1'b0, den_q};
    fits  = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= {num_q[ddo_pkg::DivW-2:0], fits};
      rem_q <= fits ? diff[ddo_pkg::DenW-1:0] : trial[ddo_pkg::DenW-1:0];
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = num_q;

endmodule

/* rtl/core/differential_drive_odometry.sv */
// Channel  | Direction | Handshake              | Payload
// step in  | in        | in_valid_i, in_stall_o | command_i, left/right_position_i, heading_in_i
// pose out | out       | out_valid_o, out_stall_i | pose_x_o, pose_y_o, pose_heading_o, flags
// config   | in        | APB psel/penable/pwrite | paddr, pwdata, prdata
//
// One item at a time. A restart goes from the idle state straight to the output state.
// A straight step runs one CORDIC pass, two products and the position update; an arc step
// runs the shared bit-serial divider twice (radius, then turn angle) and two CORDIC runs.
// Reset clears the pose, the stored wheel positions and the registers to their defaults.
// A stalled result holds, and no new item is taken until it has been delivered.
module differential_drive_odometry #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [31:0] left_position_i,
  input  logic [31:0] right_position_i,
  input  logic [15:0] heading_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pose_x_o,
  output logic [31:0] pose_y_o,
  output logic [15:0] pose_heading_o,
  output logic        went_straight_o,
  output logic        saturated_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic signed [34:0] PosHi = 35'sh0_7FFF_FFFF;
  localparam logic signed [34:0] PosLo = -PosHi - 35'sd1;

  ddo_pkg::ddo_state_e state_q, state_d;

  logic [30:0]        track_width_q;
  logic [15:0]        eps_q, start_heading_q;
  logic signed [31:0] start_x_q, start_y_q;

  logic signed [31:0] pos_x_q, pos_y_q, prev_l_q, prev_r_q;
  logic [15:0]        heading_q, h_q;
  logic signed [31:0] dl_q, dr_q, c1_q, s1_q;
  logic signed [32:0] dc_q;
  logic [31:0]        mul_a_q, mul_b_q;
  logic signed [33:0] dx_q, dy_q;
  logic [30:0]        rad_q;
  logic               rad_neg_q, neg_q;
  logic [61:0]        ang_prod_q;
  logic               straight_q, sat_q;

  logic               accept, cfg_wr;
  logic signed [32:0] dl_full, dr_full, diff, sum, ds, dc;
  logic [32:0]        dl_sat, dr_sat, mag_diff, mag_sum, mag_ds, mag_dc;
  logic [32:0]        px_sat, py_sat;
  logic [30:0]        w_eff;
  logic [63:0]        prod, rad_dividend;
  logic [32:0]        prod_top;
  logic signed [33:0] prod_pos, prod_neg;
  logic               straight;
  logic [31:0]        w32;

  logic                     cordic_start, div_start;
  logic [31:0]              cordic_angle;
  logic [ddo_pkg::DivW-1:0] div_dividend;
  logic [ddo_pkg::DenW-1:0] div_divisor;
  ddo_pkg::cordic_res_t     cres;
  ddo_pkg::div_res_t        dres;

  // Returns {clamped flag, value} for a sum that may leave the position range.
  function automatic logic [32:0] clamp_f(input logic signed [34:0] v);
    logic [32:0] r;
    if (v > PosHi)      r = {1'b1, PosHi[31:0]};
    else if (v < PosLo) r = {1'b1, PosLo[31:0]};
    else                r = {1'b0, v[31:0]};
    return r;
  endfunction

  function automatic logic [32:0] mag_f(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_width_q   <= 31'd65536;
      eps_q           <= 16'd1;
      start_x_q       <= '0;
      start_y_q       <= '0;
      start_heading_q <= '0;
    end else if (cfg_wr) begin
      unique case (ddo_pkg::reg_idx_e'(paddr[4:2]))
        ddo_pkg::REG_TRACK_WIDTH:   track_width_q   <= pwdata[30:0];
        ddo_pkg::REG_EPSILON:       eps_q           <= pwdata[15:0];
        ddo_pkg::REG_START_X:       start_x_q       <= pwdata;
        ddo_pkg::REG_START_Y:       start_y_q       <= pwdata;
        ddo_pkg::REG_START_HEADING: start_heading_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ddo_pkg::reg_idx_e'(paddr[4:2]))
      ddo_pkg::REG_TRACK_WIDTH:   prdata = {1'b0, track_width_q};
      ddo_pkg::REG_EPSILON:       prdata = {16'd0, eps_q};
      ddo_pkg::REG_START_X:       prdata = start_x_q;
      ddo_pkg::REG_START_Y:       prdata = start_y_q;
      ddo_pkg::REG_START_HEADING: prdata = {16'd0, start_heading_q};
      default:                    prdata = '0;
    endcase
  end

  // Shared datapath terms.
  always_comb begin
    dl_full  = 33'(signed'(left_position_i)) - 33'(prev_l_q);
    dr_full  = 33'(signed'(right_position_i)) - 33'(prev_r_q);
    dl_sat   = clamp_f(35'(dl_full));
    dr_sat   = clamp_f(35'(dr_full));
    diff     = 33'(dr_q) - 33'(dl_q);
    sum      = 33'(dr_q) + 33'(dl_q);
    mag_diff = mag_f(diff);
    mag_sum  = mag_f(sum);
    straight = (diff == '0) || (mag_diff < 33'(eps_q));
    w_eff    = (track_width_q == '0) ? 31'd1 : track_width_q;
    ds       = 33'(cres.sin) - 33'(s1_q);
    dc       = 33'(c1_q) - 33'(cres.cos);
    mag_ds   = mag_f(ds);
    mag_dc   = mag_f(dc_q);
    // The one multiplier: operand registers in, product consumed into a register.
    prod     = 64'(mul_a_q) * 64'(mul_b_q);
    prod_top = prod[62:30];
    prod_pos = signed'({1'b0, prod_top});
    prod_neg = -prod_pos;
    // W times |sum| where |sum| may reach exactly 2^32.
    rad_dividend = prod + (mag_sum[32] ? {1'b0, w_eff, 32'd0} : 64'd0);
    w32      = diff[32] ? -dres.quot[31:0] : dres.quot[31:0];
    px_sat   = clamp_f(35'(pos_x_q) + 35'(dx_q));
    py_sat   = clamp_f(35'(pos_y_q) + 35'(dy_q));
  end

  assign accept = in_valid_i && (state_q == ddo_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ddo_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d      = state_q;
    cordic_start = 1'b0;
    cordic_angle = {h_q, 16'd0} + w32;
    div_start    = 1'b0;
    div_dividend = rad_dividend;
    div_divisor  = {mag_diff, 1'b0};
    unique case (state_q)
      ddo_pkg::ST_IDLE: begin
        cordic_angle = {heading_in_i, 16'd0};
        if (accept) begin
          if (command_i) begin
            state_d = ddo_pkg::ST_OUT;
          end else begin
            cordic_start = 1'b1;
            state_d      = ddo_pkg::ST_CS1;
          end
        end
      end
      ddo_pkg::ST_CS1: begin
        if (cres.done) state_d = straight ? ddo_pkg::ST_SX : ddo_pkg::ST_RMUL;
      end
      ddo_pkg::ST_SX: state_d = ddo_pkg::ST_SY;
      ddo_pkg::ST_SY: state_d = ddo_pkg::ST_POS;
      ddo_pkg::ST_RMUL: begin
        div_start = 1'b1;
        state_d   = ddo_pkg::ST_RDIV;
      end
      ddo_pkg::ST_RDIV: begin
        div_dividend = {2'b00, ang_prod_q};
        div_divisor  = {3'd0, w_eff};
        if (dres.done) begin
          div_start = 1'b1;
          state_d   = ddo_pkg::ST_ADIV;
        end
      end
      ddo_pkg::ST_ADIV: begin
        if (dres.done) begin
          cordic_start = 1'b1;
          state_d      = ddo_pkg::ST_CS2;
        end
      end
      ddo_pkg::ST_CS2: begin
        if (cres.done) state_d = ddo_pkg::ST_AX;
      end
      ddo_pkg::ST_AX:  state_d = ddo_pkg::ST_AY;
      ddo_pkg::ST_AY:  state_d = ddo_pkg::ST_POS;
      ddo_pkg::ST_POS: state_d = ddo_pkg::ST_OUT;
      ddo_pkg::ST_OUT: begin
        if (!out_stall_i) state_d = ddo_pkg::ST_IDLE;
      end
      default: state_d = ddo_pkg::ST_IDLE;
    endcase
  end

  // Pose and stored wheel positions.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q    <= '0;
      pos_y_q    <= '0;
      heading_q  <= '0;
      prev_l_q   <= '0;
      prev_r_q   <= '0;
      straight_q <= 1'b0;
      sat_q      <= 1'b0;
    end else begin
      if (accept) begin
        straight_q <= 1'b0;
        if (command_i) begin
          pos_x_q   <= start_x_q;
          pos_y_q   <= start_y_q;
          heading_q <= start_heading_q;
          prev_l_q  <= '0;
          prev_r_q  <= '0;
          sat_q     <= 1'b0;
        end else begin
          prev_l_q <= signed'(left_position_i);
          prev_r_q <= signed'(right_position_i);
          sat_q    <= dl_sat[32] | dr_sat[32];
        end
      end
      if (state_q == ddo_pkg::ST_CS1 && cres.done) straight_q <= straight;
      if (state_q == ddo_pkg::ST_RDIV && dres.done && (|dres.quot[63:31])) sat_q <= 1'b1;
      if (state_q == ddo_pkg::ST_POS) begin
        pos_x_q   <= px_sat[31:0];
        pos_y_q   <= py_sat[31:0];
        heading_q <= h_q;
        sat_q     <= sat_q | px_sat[32] | py_sat[32];
      end
    end
  end

  // Working registers of one step.
  always_ff @(posedge clk_i) begin
    case (state_q) inside
      ddo_pkg::ST_IDLE: begin
        if (accept && !command_i) begin
          dl_q <= dl_sat[31:0];
          dr_q <= dr_sat[31:0];
          h_q  <= heading_in_i;
        end
      end
      ddo_pkg::ST_CS1: begin
        if (cres.done) begin
          c1_q <= cres.cos;
          s1_q <= cres.sin;
          if (straight) begin
            mul_a_q <= 32'(mag_f(33'(dr_q)));
            mul_b_q <= 32'(mag_f(33'(cres.cos)));
            neg_q   <= dr_q[31] ^ cres.cos[31];
          end else begin
            mul_a_q <= {1'b0, w_eff};
            mul_b_q <= mag_sum[31:0];
          end
        end
      end
      ddo_pkg::ST_SX: begin
        dx_q    <= neg_q ? prod_neg : prod_pos;
        mul_b_q <= 32'(mag_f(33'(s1_q)));
        neg_q   <= dr_q[31] ^ s1_q[31];
      end
      ddo_pkg::ST_SY, ddo_pkg::ST_AY: begin
        dy_q <= neg_q ? prod_neg : prod_pos;
      end
      ddo_pkg::ST_RMUL: begin
        mul_a_q <= mag_diff[31:0];
        mul_b_q <= ddo_pkg::TurnPerRad;
      end
      ddo_pkg::ST_RDIV: begin
        ang_prod_q <= prod[61:0];
        if (dres.done) begin
          rad_q     <= (|dres.quot[63:31]) ? 31'h7FFF_FFFF : dres.quot[30:0];
          rad_neg_q <= sum[32] ^ diff[32];
        end
      end
      ddo_pkg::ST_CS2: begin
        if (cres.done) begin
          dc_q    <= dc;
          mul_a_q <= {1'b0, rad_q};
          mul_b_q <= mag_ds[31:0];
          neg_q   <= rad_neg_q ^ ds[32];
        end
      end
      ddo_pkg::ST_AX: begin
        dx_q    <= neg_q ? prod_neg : prod_pos;
        mul_b_q <= mag_dc[31:0];
        neg_q   <= rad_neg_q ^ dc_q[32];
      end
      default: ;
    endcase
  end

  ddo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (cordic_angle),
    .res_o   (cres)
  );

  ddo_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .res_o      (dres)
  );

  assign in_stall_o      = (state_q != ddo_pkg::ST_IDLE);
  assign out_valid_o     = (state_q == ddo_pkg::ST_OUT);
  assign pose_x_o        = pos_x_q;
  assign pose_y_o        = pos_y_q;
  assign pose_heading_o  = heading_q;
  assign went_straight_o = straight_q;
  assign saturated_o     = sat_q;

endmodule

/* rtl/core/ddo_checker.sv */
// Port-level checks of the odometry block, bound to the top level.
// Depends on differential_drive_odometry_defines.svh for the assertion macros.
`include "differential_drive_odometry_defines.svh"

module ddo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] pose_x_o
);

  // A stalled result stays offered with the same pose.
  `DDO_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(pose_x_o))

  // Only one item is in the block, so no item is taken while a result is offered.
  `DDO_ASSERT(a_one_item, out_valid_o |-> in_stall_o)

  // Once an item is taken the block is busy on the next edge.
  `DDO_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o)

  // A reset edge leaves the block idle, so no result is offered right after it.
  `DDO_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o)

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (.*);

/* tb/differential_drive_odometry_checker.sv */
// Pose checker for the odometry block: watches both item channels and the register port,
// predicts each pose from its own fixed point model and compares all of its fields.
// Depends on ddo_pkg for the register indexes, the arctangent table and the scale constants.
`timescale 1ns / 1ps
module differential_drive_odometry_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        command_i,
  input  logic [31:0] left_position_i,
  input  logic [31:0] right_position_i,
  input  logic [15:0] heading_in_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] pose_x_i,
  input  logic [31:0] pose_y_i,
  input  logic [15:0] pose_heading_i,
  input  logic        went_straight_i,
  input  logic        saturated_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors_o,
  output int          pending_o
);

  localparam int unsigned Steps = 16;
  localparam longint PosMax = 64'sd2147483647;
  localparam longint PosMin = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] hdg;
    logic        straight;
    logic        sat;
  } pose_t;

  pose_t poses_due[$];

  logic [30:0] track_w;
  logic [15:0] eps;
  logic [31:0] home_x, home_y;
  logic [15:0] home_hdg;
  longint      cur_x, cur_y, last_l, last_r;
  logic [15:0] cur_hdg;

  function automatic longint clamp(input longint v, inout bit sat);
    if (v > PosMax) begin
      sat = 1;
      return PosMax;
    end
    if (v < PosMin) begin
      sat = 1;
      return PosMin;
    end
    return v;
  endfunction

  // sign(a*b) * floor(|a|*|b| / 2^30)
  function automatic longint trig_mul(input longint a, input longint b);
    logic [127:0] p;
    longint r;
    p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
    r = longint'(p >> ddo_pkg::TrigShift);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  task automatic sincos(input logic [31:0] ang, output longint c, output longint s);
    longint z, x, y, xs, ys;
    bit flip;
    z = longint'($signed(ang));
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 64'sh40000000) begin
      z -= 64'sh80000000;
      flip = 1;
    end else if (z < -64'sh40000000) begin
      z += 64'sh80000000;
      flip = 1;
    end
    for (int i = 0; i < Steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= longint'(ddo_pkg::atan_f(5'(i)));
      end else begin
        x += ys;
        y -= xs;
        z += longint'(ddo_pkg::atan_f(5'(i)));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic advance_pose(input logic cmd, input logic [31:0] lp, input logic [31:0] rp,
                              input logic [15:0] h);
    pose_t p;
    bit sat;
    longint dl, dr, diff, sum, dx, dy, c1, s1, c2, s2, rad, adiff;
    logic [127:0] num, q;
    logic [31:0] h32, w32;
    logic [63:0] w;
    sat = 0;
    p.straight = 0;
    if (cmd) begin
      cur_x = longint'($signed(home_x));
      cur_y = longint'($signed(home_y));
      cur_hdg = home_hdg;
      last_l = 0;
      last_r = 0;
    end else begin
      h32 = {h, 16'h0};
      dl = clamp(longint'($signed(lp)) - last_l, sat);
      dr = clamp(longint'($signed(rp)) - last_r, sat);
      last_l = longint'($signed(lp));
      last_r = longint'($signed(rp));
      diff = dr - dl;
      sum = dl + dr;
      adiff = diff < 0 ? -diff : diff;
      sincos(h32, c1, s1);
      if (diff == 0 || adiff < longint'(eps)) begin
        p.straight = 1;
        dx = trig_mul(dr, c1);
        dy = trig_mul(dr, s1);
      end else begin
        w = (track_w == 0) ? 64'd1 : 64'(track_w);
        num = 128'(w) * 128'(sum < 0 ? -sum : sum);
        q = num / 128'(2 * adiff);
        if (q > 128'(PosMax)) begin
          sat = 1;
          q = 128'(PosMax);
        end
        rad = ((sum < 0) != (diff < 0)) ? -longint'(q) : longint'(q);
        q = (128'(adiff) * 128'(ddo_pkg::TurnPerRad)) / 128'(w);
        w32 = q[31:0];
        if (diff < 0) w32 = -w32;
        sincos(h32 + w32, c2, s2);
        dx = trig_mul(rad, s2 - s1);
        dy = trig_mul(rad, c1 - c2);
      end
      cur_x = clamp(cur_x + dx, sat);
      cur_y = clamp(cur_y + dy, sat);
      cur_hdg = h;
    end
    p.x = cur_x[31:0];
    p.y = cur_y[31:0];
    p.hdg = cur_hdg;
    p.sat = sat;
    poses_due.push_back(p);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pose_t e;
    if (!rst_ni) begin
      track_w <= 31'd65536;
      eps <= 16'd1;
      home_x <= '0;
      home_y <= '0;
      home_hdg <= '0;
      cur_x = 0;
      cur_y = 0;
      cur_hdg = '0;
      last_l = 0;
      last_r = 0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (ddo_pkg::reg_idx_e'(paddr[4:2]))
          ddo_pkg::REG_TRACK_WIDTH:   track_w <= pwdata[30:0];
          ddo_pkg::REG_EPSILON:       eps <= pwdata[15:0];
          ddo_pkg::REG_START_X:       home_x <= pwdata;
          ddo_pkg::REG_START_Y:       home_y <= pwdata;
          ddo_pkg::REG_START_HEADING: home_hdg <= pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        advance_pose(command_i, left_position_i, right_position_i, heading_in_i);
      if (out_valid_i && !out_stall_i) begin
        if (poses_due.size() == 0) begin
          $display("%0t: pose with none expected, got %h %h %h %b %b", $time, pose_x_i,
                   pose_y_i, pose_heading_i, went_straight_i, saturated_i);
          errors_o <= errors_o + 1;
        end else begin
          e = poses_due.pop_front();
          if (e != {pose_x_i, pose_y_i, pose_heading_i, went_straight_i, saturated_i}) begin
            $display("%0t: pose mismatch expected x %h y %h h %h st %b sat %b", $time,
                     e.x, e.y, e.hdg, e.straight, e.sat);
            $display("%0t:                  actual x %h y %h h %h st %b sat %b", $time,
                     pose_x_i, pose_y_i, pose_heading_i, went_straight_i, saturated_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      pending_o <= poses_due.size();
    end
  end
endmodule

/* tb/differential_drive_odometry_tb.sv */
// Top of the odometry block's testbench: clock, reset, register writes and step items.
// Depends on ddo_pkg, the block and differential_drive_odometry_checker.
`timescale 1ns / 1ps
module differential_drive_odometry_tb;

  logic        clk_i = 0, rst_ni = 0;
  logic        in_valid_i = 0, out_stall_i = 0, command_i = 0;
  logic [31:0] left_position_i = 0, right_position_i = 0;
  logic [15:0] heading_in_i = 0;
  logic        in_stall_o, out_valid_o, went_straight_o, saturated_o, pready;
  logic [31:0] pose_x_o, pose_y_o, prdata;
  logic [15:0] pose_heading_o;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  int          errors, pending;
  int          send_idle = 0, stall_pct = 0;
  longint      cycles = 0;
  logic [31:0] wheel_l = 0, wheel_r = 0;

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  differential_drive_odometry DUT (.*);

  differential_drive_odometry_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .command_i, .left_position_i,
    .right_position_i, .heading_in_i, .out_valid_i(out_valid_o), .out_stall_i,
    .pose_x_i(pose_x_o), .pose_y_i(pose_y_o), .pose_heading_i(pose_heading_o),
    .went_straight_i(went_straight_o), .saturated_i(saturated_o), .psel, .penable, .pwrite,
    .pready, .paddr, .pwdata, .errors_o(errors), .pending_o(pending));

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    out_stall_i <= ($urandom_range(99) < stall_pct);
    if (cycles > 64'd3000000) begin
      $display("differential_drive_odometry regression: fail");
      $finish;
    end
  end

  // Ends with psel low while it waits for a clock edge, so that back to back writes each get their own setup cycle.
  task automatic write_reg(input ddo_pkg::reg_idx_e idx, input logic [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk_i);
  endtask

  // Valid stays high after an item is taken; the next call either replaces the item in the
  // same cycle or drops valid for its idle cycles.
  task automatic send_step(input logic cmd, input logic [31:0] lp, input logic [31:0] rp,
                           input logic [15:0] h);
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle) @(posedge clk_i);
    end
    in_valid_i <= 1;
    command_i <= cmd;
    left_position_i <= lp;
    right_position_i <= rp;
    heading_in_i <= h;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // Mostly smooth wheel motion so arcs and straight runs both occur, with jumps and restarts now and then.
  task automatic random_step();
    int r;
    logic [31:0] dl, dr;
    r = $urandom_range(99);
    if (r < 4) begin
      send_step(1'b1, $urandom, $urandom, 16'($urandom));
      wheel_l = 0;
      wheel_r = 0;
      return;
    end
    dl = $signed($urandom_range(262144)) - 131072;
    if (r < 30) dr = dl + $signed($urandom_range(4)) - 2;
    else if (r < 85) dr = $signed($urandom_range(262144)) - 131072;
    else begin
      dl = $urandom;
      dr = $urandom;
    end
    wheel_l = wheel_l + dl;
    wheel_r = wheel_r + dr;
    send_step(1'b0, wheel_l, wheel_r, 16'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: restart, extremes, equal deltas, huge deltas.
    send_step(1'b1, '0, '0, '0);
    send_step(1'b0, 32'h0001_0000, 32'h0001_0000, 16'h0000);
    send_step(1'b0, 32'h0002_0000, 32'h0003_0000, 16'h4000);
    send_step(1'b0, 32'h7fff_ffff, 32'h8000_0000, 16'hffff);
    send_step(1'b0, 32'h8000_0000, 32'h7fff_ffff, 16'h8000);
    send_step(1'b0, 32'hffff_ffff, 32'h0000_0000, 16'hc000);
    send_step(1'b0, 32'h0000_0000, 32'h0000_0001, 16'h2000);
    send_step(1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 16'h5555);
    send_step(1'b0, 32'h7fff_fff0, 32'h7fff_ffff, 16'haaaa);
    drain();
    write_reg(ddo_pkg::REG_TRACK_WIDTH, 32'd0);
    write_reg(ddo_pkg::REG_EPSILON, 32'd0);
    write_reg(ddo_pkg::REG_START_X, 32'h7fff_ffff);
    write_reg(ddo_pkg::REG_START_Y, 32'h8000_0000);
    write_reg(ddo_pkg::REG_START_HEADING, 32'h0000_ffff);
    send_step(1'b1, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
    send_step(1'b0, 32'h0000_0005, 32'h0000_0005, 16'h1234);
    send_step(1'b0, 32'h0000_0006, 32'h0000_0009, 16'h0000);
    send_step(1'b0, 32'h4000_0000, 32'hc000_0000, 16'h8000);
    drain();
    write_reg(ddo_pkg::REG_TRACK_WIDTH, 32'h7fff_ffff);
    write_reg(ddo_pkg::REG_EPSILON, 32'h0000_ffff);
    write_reg(ddo_pkg::REG_START_X, 32'hfff0_0000);
    write_reg(ddo_pkg::REG_START_Y, 32'h0010_0000);
    send_step(1'b1, '0, '0, '0);
    send_step(1'b0, 32'h0000_8000, 32'h0001_0000, 16'h7000);
    send_step(1'b0, 32'h0010_0000, 32'h0000_0000, 16'h9000);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 59; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 59; end
        default: begin send_idle = 33; stall_pct = 33; end
      endcase
      write_reg(ddo_pkg::REG_TRACK_WIDTH,
                (ph == 3) ? 32'd1 : $urandom_range(32'h0008_0000, 32'h4000));
      write_reg(ddo_pkg::REG_EPSILON, (ph == 5) ? 32'h0000_ffff : $urandom_range(64));
      write_reg(ddo_pkg::REG_START_X, $urandom);
      write_reg(ddo_pkg::REG_START_Y, $urandom);
      write_reg(ddo_pkg::REG_START_HEADING, $urandom);
      send_step(1'b1, '0, '0, '0);
      wheel_l = 0;
      wheel_r = 0;
      for (int n = 0; n < 180; n++) random_step();
      drain();
      stall_pct = 0;
    end
    if (errors == 0) begin
      $display("differential_drive_odometry regression: pass");
    end else begin
      $display("differential_drive_odometry regression: fail");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ddo_pkg.sv
rtl/core/ddo_cordic.sv
rtl/core/ddo_divider.sv
rtl/core/differential_drive_odometry.sv
rtl/core/ddo_checker.sv
tb/differential_drive_odometry_checker.sv
tb/differential_drive_odometry_tb.sv
